// ----- rtl/s2c_pkg.sv -----
// s2c_pkg: shared types, constants and pipeline sizing for the sphere-to-cube mapper.
// No dependencies; imported by every other file in rtl/.
package s2c_pkg;

    localparam int DATA_W        = 32;  // width of every coordinate field
    localparam int IFRAC         = 30;  // internal fixed point fraction bits
    localparam int FRAC_BITS_DEF = 30;  // default coordinate fraction bits

    // square root pipelines: radicand width and digit steps per register stage
    localparam int SQRT_W      = 64;
    localparam int SQRT_STEPS  = 4;
    localparam int SQRT_STAGES = (SQRT_W / 2 + SQRT_STEPS - 1) / SQRT_STEPS;

    // front end stages, then outer root, tangent radicand stage, two roots, output stage
    localparam int FRONT_STAGES = 5;
    localparam int LATENCY      = FRONT_STAGES + SQRT_STAGES + 1 + SQRT_STAGES + 1;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] point_x;
        logic signed [DATA_W-1:0] point_y;
        logic signed [DATA_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] cube_x;
        logic signed [DATA_W-1:0] cube_y;
        logic signed [DATA_W-1:0] cube_z;
    } cube_t;

    // per-item info that rides alongside the outer root
    typedef struct packed {
        axis_t             face;
        logic              neg_face;
        logic              neg_u;
        logic              neg_v;
        logic              zero_u;
        logic              zero_v;
        logic [DATA_W-1:0] u2;      // 2u^2, Q.30
        logic [DATA_W-1:0] v2;      // 2v^2, Q.30
    } front_side_t;

endpackage

// ----- rtl/s2c_isqrt.sv -----
// s2c_isqrt: pipelined digit-by-digit integer square root, floor(sqrt(rad)).
// Depends on s2c_pkg for default sizing; carries a sideband word with each item.
module s2c_isqrt
    import s2c_pkg::*;
#(
    parameter int W      = SQRT_W,
    parameter int SIDE_W = 1,
    parameter int STEPS  = SQRT_STEPS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [W-1:0]      in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [W/2-1:0]    out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int ITERS = W / 2;
    localparam int NSTG  = (ITERS + STEPS - 1) / STEPS;

    logic [W-1:0]      v_in     [NSTG];
    logic [W-1:0]      r_in     [NSTG];
    logic [SIDE_W-1:0] side_in  [NSTG];
    logic              valid_in [NSTG];
    logic [W-1:0]      v_next   [NSTG];
    logic [W-1:0]      r_next   [NSTG];
    logic [W-1:0]      v_reg    [NSTG];
    logic [W-1:0]      r_reg    [NSTG];
    logic [SIDE_W-1:0] side_reg [NSTG];
    logic              valid_reg[NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign v_in[s]     = in_rad;
            assign r_in[s]     = '0;
            assign side_in[s]  = in_side;
            assign valid_in[s] = in_valid;
        end else begin : g_rest
            assign v_in[s]     = v_reg[s-1];
            assign r_in[s]     = r_reg[s-1];
            assign side_in[s]  = side_reg[s-1];
            assign valid_in[s] = valid_reg[s-1];
        end

        // STEPS result bits per stage, most significant first
        always_comb
        begin
            logic [W-1:0] v_t;
            logic [W-1:0] r_t;
            logic [W-1:0] b_t;
            v_t = v_in[s];
            r_t = r_in[s];
            b_t = '0;
            for (int j = 0; j < STEPS; j++)
            begin
                if (s * STEPS + j < ITERS)
                begin
                    b_t = W'(1) << (W - 2 - 2 * (s * STEPS + j));
                    if (v_t >= r_t + b_t)
                    begin
                        v_t = v_t - (r_t + b_t);
                        r_t = (r_t >> 1) + b_t;
                    end
                    else
                    begin
                        r_t = r_t >> 1;
                    end
                end
            end
            v_next[s] = v_t;
            r_next[s] = r_t;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else
                valid_reg[s] <= valid_in[s];
        end

        always_ff @(posedge clk)
        begin
            v_reg[s]    <= v_next[s];
            r_reg[s]    <= r_next[s];
            side_reg[s] <= side_in[s];
        end
    end

    assign out_valid = valid_reg[NSTG-1];
    assign out_root  = r_reg[NSTG-1][W/2-1:0];
    assign out_side  = side_reg[NSTG-1];

endmodule

// ----- rtl/s2c_front.sv -----
// s2c_front: magnitude/face selection, doubled squares and outer-root radicand (5 stages).
// Depends on s2c_pkg.
module s2c_front
    import s2c_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  point_t        point,
    output logic          rad_valid,
    output logic [63:0]   rad,
    output front_side_t   side
);

    localparam logic [63:0] LIM  = 64'(1) << FRAC_BITS;
    localparam int          SH_R = (FRAC_BITS >= IFRAC) ? FRAC_BITS - IFRAC : 0;
    localparam int          SH_L = (FRAC_BITS < IFRAC) ? IFRAC - FRAC_BITS : 0;
    localparam logic [36:0] NINE_ONE = 37'(9) << IFRAC;

    // stage 1: magnitudes, internal Q.30, face axis
    logic [DATA_W-1:0] w    [3];
    logic [DATA_W-1:0] mag1 [3];
    logic [30:0]       m1   [3];
    axis_t             face1;

    logic [30:0]       m_reg    [3];
    logic [2:0]        neg_reg;
    logic [2:0]        zero_reg;
    axis_t             face_reg;
    logic              v1_reg;

    assign w[0] = point.point_x;
    assign w[1] = point.point_y;
    assign w[2] = point.point_z;

    always_comb
    begin
        logic [63:0] m64;
        m64 = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag1[i] = w[i][DATA_W-1] ? (~w[i] + 32'd1) : w[i];
            m64 = {32'b0, mag1[i]};
            if (m64 > LIM)
                m64 = LIM;
            if (FRAC_BITS >= IFRAC)
                m64 = m64 >> SH_R;
            else
                m64 = m64 << SH_L;
            m1[i] = m64[30:0];
        end
    end

    always_comb
    begin
        if (mag1[0] >= mag1[1] && mag1[0] >= mag1[2])
            face1 = AXIS_X;
        else if (mag1[1] >= mag1[2])
            face1 = AXIS_Y;
        else
            face1 = AXIS_Z;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            m_reg[i]    <= m1[i];
            neg_reg[i]  <= w[i][DATA_W-1];
            zero_reg[i] <= (mag1[i] == '0);
        end
        face_reg <= face1;
    end

    // stage 2: pick tangent axes, doubled squares
    logic [1:0]  ua;
    logic [1:0]  va;
    logic [30:0] mu;
    logic [30:0] mv;
    logic [61:0] pu;
    logic [61:0] pv;
    front_side_t s2_next;
    front_side_t s2_reg;
    logic        v2_reg;

    always_comb
    begin
        case (face_reg)
            AXIS_X:  begin ua = 2'd1; va = 2'd2; end
            AXIS_Y:  begin ua = 2'd0; va = 2'd2; end
            default: begin ua = 2'd0; va = 2'd1; end
        endcase
        mu = m_reg[ua];
        mv = m_reg[va];
        pu = {31'b0, mu} * {31'b0, mu};
        pv = {31'b0, mv} * {31'b0, mv};
        s2_next.face     = face_reg;
        s2_next.neg_face = neg_reg[face_reg];
        s2_next.neg_u    = neg_reg[ua];
        s2_next.neg_v    = neg_reg[va];
        s2_next.zero_u   = zero_reg[ua];
        s2_next.zero_v   = zero_reg[va];
        s2_next.u2       = pu[60:29];   // 2m^2 >> 30
        s2_next.v2       = pv[60:29];
    end

    always_ff @(posedge clk)
        s2_reg <= s2_next;

    // stage 3: |U-V| and k = 9 - 6(U+V)
    logic [31:0] d_next;
    logic [36:0] k_next;
    logic [32:0] sum3;
    logic [31:0] d_reg;
    logic [36:0] k_reg;
    front_side_t s3_reg;
    logic        v3_reg;

    always_comb
    begin
        d_next = (s2_reg.u2 > s2_reg.v2) ? s2_reg.u2 - s2_reg.v2 : s2_reg.v2 - s2_reg.u2;
        sum3   = {1'b0, s2_reg.u2} + {1'b0, s2_reg.v2};
        k_next = NINE_ONE - (37'(sum3) * 37'd6);
    end

    always_ff @(posedge clk)
    begin
        d_reg  <= d_next;
        k_reg  <= k_next;
        s3_reg <= s2_reg;
    end

    // stage 4: (U-V)^2
    logic [63:0] d2_reg;
    logic [36:0] k4_reg;
    front_side_t s4_reg;
    logic        v4_reg;

    always_ff @(posedge clk)
    begin
        d2_reg <= {32'b0, d_reg} * {32'b0, d_reg};
        k4_reg <= k_reg;
        s4_reg <= s3_reg;
    end

    // stage 5: radicand, clamped at zero
    logic [63:0] rad_next;
    logic [36:0] negk;
    logic [63:0] need;
    logic [63:0] rad_reg;
    front_side_t s5_reg;
    logic        v5_reg;

    always_comb
    begin
        negk = 37'(0) - k4_reg;
        need = 64'(negk) << IFRAC;
        if (!k4_reg[36])
            rad_next = d2_reg + (64'(k4_reg) << IFRAC);
        else if (d2_reg >= need)
            rad_next = d2_reg - need;
        else
            rad_next = '0;
    end

    always_ff @(posedge clk)
    begin
        rad_reg <= rad_next;
        s5_reg  <= s4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    assign rad_valid = v5_reg;
    assign rad       = rad_reg;
    assign side      = s5_reg;

endmodule

// ----- rtl/s2c_back.sv -----
// s2c_back: tangent radicands, two parallel root pipelines, output conversion and packing.
// Depends on s2c_pkg and s2c_isqrt.
module s2c_back
    import s2c_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  logic [31:0]       q,
    input  front_side_t       side,
    output logic              done,
    output cube_t             cube
);

    localparam logic [35:0] THREE_ONE = 36'(3) << IFRAC;
    localparam logic [31:0] ONE_I     = 32'(1) << IFRAC;
    localparam int          SH_UP     = (FRAC_BITS >= IFRAC) ? FRAC_BITS - IFRAC : 0;
    localparam int          SH_DN     = (FRAC_BITS < IFRAC) ? IFRAC - FRAC_BITS : 0;
    localparam logic [63:0] RND       = (64'(1) << SH_DN) >> 1;
    localparam logic [63:0] ONE_F     = 64'(1) << FRAC_BITS;

    typedef struct packed {
        axis_t face;
        logic  neg_face;
        logic  neg;
        logic  zero;
    } u_side_t;

    typedef struct packed {
        logic neg;
        logic zero;
    } v_side_t;

    // tangent radicand stage: t = 3 + U - V - q (3 + V - U - q for v), clamped at zero, scaled by 2^29
    logic [35:0] tu;
    logic [35:0] tv;
    logic [63:0] rad_u_next;
    logic [63:0] rad_v_next;
    logic [63:0] rad_u_reg;
    logic [63:0] rad_v_reg;
    u_side_t     su_next;
    v_side_t     sv_next;
    u_side_t     su_reg;
    v_side_t     sv_reg;
    logic        vt_reg;

    always_comb
    begin
        tu = THREE_ONE + {4'b0, side.u2} - {4'b0, side.v2} - {4'b0, q};
        tv = THREE_ONE + {4'b0, side.v2} - {4'b0, side.u2} - {4'b0, q};
        rad_u_next = tu[35] ? 64'(0) : (64'(tu[34:0]) << (IFRAC - 1));
        rad_v_next = tv[35] ? 64'(0) : (64'(tv[34:0]) << (IFRAC - 1));
        su_next.face     = side.face;
        su_next.neg_face = side.neg_face;
        su_next.neg      = side.neg_u;
        su_next.zero     = side.zero_u;
        sv_next.neg      = side.neg_v;
        sv_next.zero     = side.zero_v;
    end

    always_ff @(posedge clk)
    begin
        rad_u_reg <= rad_u_next;
        rad_v_reg <= rad_v_next;
        su_reg    <= su_next;
        sv_reg    <= sv_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vt_reg <= 1'b0;
        else
            vt_reg <= q_valid;
    end

    logic        ru_valid;
    logic        rv_valid;
    logic [31:0] root_u;
    logic [31:0] root_v;
    u_side_t     su_out;
    v_side_t     sv_out;

    s2c_isqrt #(
        .W      (SQRT_W),
        .SIDE_W ($bits(u_side_t)),
        .STEPS  (SQRT_STEPS)
    ) u_root_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vt_reg),
        .in_rad    (rad_u_reg),
        .in_side   (su_reg),
        .out_valid (ru_valid),
        .out_root  (root_u),
        .out_side  (su_out)
    );

    s2c_isqrt #(
        .W      (SQRT_W),
        .SIDE_W ($bits(v_side_t)),
        .STEPS  (SQRT_STEPS)
    ) u_root_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vt_reg),
        .in_rad    (rad_v_reg),
        .in_side   (sv_reg),
        .out_valid (rv_valid),
        .out_root  (root_v),
        .out_side  (sv_out)
    );

    // saturate to +-1.0 in the output format and apply sign
    function automatic logic [31:0] pack_mag(input logic [63:0] mag_in, input logic neg);
        logic [63:0] mag;
        mag = (mag_in > ONE_F) ? ONE_F : mag_in;
        if (neg)
        begin
            if (mag > 64'h8000_0000)
                mag = 64'h8000_0000;
            return 32'(64'(0) - mag);
        end
        if (mag > 64'h7FFF_FFFF)
            mag = 64'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    function automatic logic [31:0] tangent_out(input logic [31:0] root, input logic neg,
                                                input logic zero);
        logic [63:0] r;
        r = (root > ONE_I) ? 64'(ONE_I) : 64'(root);
        if (FRAC_BITS >= IFRAC)
            r = r << SH_UP;
        else
            r = (r + RND) >> SH_DN;
        return zero ? 32'd0 : pack_mag(r, neg);
    endfunction

    logic [31:0] face_val;
    logic [31:0] u_val;
    logic [31:0] v_val;
    cube_t       cube_next;
    cube_t       cube_reg;
    logic        done_reg;

    always_comb
    begin
        face_val = pack_mag(ONE_F, su_out.neg_face);
        u_val    = tangent_out(root_u, su_out.neg, su_out.zero);
        v_val    = tangent_out(root_v, sv_out.neg, sv_out.zero);
        case (su_out.face)
            AXIS_X:
            begin
                cube_next.cube_x = face_val;
                cube_next.cube_y = u_val;
                cube_next.cube_z = v_val;
            end
            AXIS_Y:
            begin
                cube_next.cube_x = u_val;
                cube_next.cube_y = face_val;
                cube_next.cube_z = v_val;
            end
            default:
            begin
                cube_next.cube_x = u_val;
                cube_next.cube_y = v_val;
                cube_next.cube_z = face_val;
            end
        endcase
    end

    always_ff @(posedge clk)
        cube_reg <= cube_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ru_valid & rv_valid;
    end

    assign done = done_reg;
    assign cube = cube_reg;

endmodule

// ----- rtl/sphere_to_cube_mapper_top.sv -----
// sphere_to_cube_mapper_top: unit sphere point to unit cube point, fully pipelined.
// Depends on s2c_pkg, s2c_front, s2c_isqrt, s2c_back.
//
//  channel   | ports              | transfer when
//  ----------+--------------------+----------------------------
//  input     | start, busy, point | start high and busy low
//  result    | done, cube         | done high (one cycle each)
//
// One point per cycle, every cycle; a point passes through
// 5 front end stages, an 8-stage outer root, one tangent radicand stage,
// two 8-stage tangent roots side by side, one output stage. The root pipelines
// resolve SQRT_STEPS result bits per stage and set the depth.
// Reset clears only the valid bits; data registers are not reset.
// busy is always low: nothing downstream can stall, and the pipeline never holds.
module sphere_to_cube_mapper_top
    import s2c_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF   // coordinate fraction bits, 16..40
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    output logic   busy,
    input  point_t point,
    output logic   done,
    output cube_t  cube
);

    logic        rad_valid;
    logic [63:0] rad;
    front_side_t front_side;

    logic        q_valid;
    logic [31:0] q;
    front_side_t q_side;

    assign busy = 1'b0;

    // stages 1-5: magnitudes, face axis, 2u^2 / 2v^2, outer radicand
    s2c_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .point     (point),
        .rad_valid (rad_valid),
        .rad       (rad),
        .side      (front_side)
    );

    // outer root q = sqrt((U-V)^2 - 6(U+V) + 9)
    s2c_isqrt #(
        .W      (SQRT_W),
        .SIDE_W ($bits(front_side_t)),
        .STEPS  (SQRT_STEPS)
    ) u_outer_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rad_valid),
        .in_rad    (rad),
        .in_side   (front_side),
        .out_valid (q_valid),
        .out_root  (q),
        .out_side  (q_side)
    );

    // tangent roots, conversion to output format, result strobe
    s2c_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q       (q),
        .side    (q_side),
        .done    (done),
        .cube    (cube)
    );

endmodule

// ----- rtl/s2c_checker.sv -----
// s2c_checker: port-level assertions for sphere_to_cube_mapper_top, attached by bind.
// Depends on s2c_pkg.
module s2c_checker
    import s2c_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input logic   clk,
    input logic   rst_n,
    input logic   start,
    input logic   busy,
    input point_t point,
    input logic   done,
    input cube_t  cube
);

    localparam logic [31:0] ONE_POS = (FRAC_BITS >= 31) ? 32'h7FFF_FFFF : 32'(64'(1) << FRAC_BITS);
    localparam logic [31:0] ONE_NEG = (FRAC_BITS >= 31) ? 32'h8000_0000 :
                                      32'(64'(0) - (64'(1) << FRAC_BITS));

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("result missing after transfer");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching transfer");

    a_face_unit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cube.cube_x == ONE_POS || cube.cube_x == ONE_NEG ||
                  cube.cube_y == ONE_POS || cube.cube_y == ONE_NEG ||
                  cube.cube_z == ONE_POS || cube.cube_z == ONE_NEG))
        else $error("no face coordinate at unit magnitude");

endmodule

bind sphere_to_cube_mapper_top s2c_checker #(.FRAC_BITS(FRAC_BITS)) u_s2c_checker (.*);

// ----- sim/tb_sphere_to_cube_mapper_top.sv -----
// tb_sphere_to_cube_mapper_top: self-checking bench for the sphere-to-cube mapper.
// Depends on s2c_pkg and sphere_to_cube_mapper_top; holds its own bit-exact predictor.
module tb_sphere_to_cube_mapper_top;
    import s2c_pkg::*;

    localparam int FB       = FRAC_BITS_DEF;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 1400;
    localparam logic signed [31:0] ONE  = 32'sd1 <<< FB;
    localparam logic signed [31:0] MONE = -(32'sd1 <<< FB);
    localparam logic signed [31:0] MNEG = 32'sh8000_0000;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    point_t point = '0;
    logic   done;
    cube_t  cube;

    sphere_to_cube_mapper_top #(.FRAC_BITS(FB)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .point (point),
        .done  (done),
        .cube  (cube)
    );

    always #1 clk = ~clk;

    // Cube points still in flight through the pipeline, oldest first.
    cube_t cube_pending[$];
    int    fail_cnt  = 0;
    int    sent_cnt  = 0;
    int    recv_cnt  = 0;
    int    idle_cyc  = 0;

    // ---------------- predictor ----------------
    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // magnitude clamp to 1.0, then to internal Q.30, then 2m^2
    function automatic logic [63:0] twice_sq(logic [63:0] mag);
        logic [63:0] m;
        m = (mag > (64'd1 << FB)) ? (64'd1 << FB) : mag;
        if (FB >= IFRAC)
            m = m >> (FB - IFRAC);
        else
            m = m << (IFRAC - FB);
        return (2 * m * m) >> IFRAC;
    endfunction

    function automatic logic [63:0] outer_q(logic [63:0] a2, logic [63:0] b2);
        logic [63:0] d;
        logic [63:0] need;
        logic [63:0] r;
        longint      k;
        d = (a2 > b2) ? a2 - b2 : b2 - a2;
        k = longint'(9 * (64'd1 << IFRAC)) - longint'(6 * (a2 + b2));
        if (k >= 0)
            r = d * d + (64'(k) << IFRAC);
        else
        begin
            need = 64'(-k) << IFRAC;
            r = (d * d >= need) ? d * d - need : 0;
        end
        return int_sqrt(r);
    endfunction

    function automatic logic [31:0] tangent_coord(logic [63:0] u2, logic [63:0] v2,
                                                  logic [63:0] q, logic neg);
        longint      t;
        logic [63:0] r;
        logic [63:0] lim;
        t = longint'(3 * (64'd1 << IFRAC)) + longint'(u2) - longint'(v2) - longint'(q);
        if (t < 0)
            t = 0;
        r = int_sqrt(64'(t) << (IFRAC - 1));
        if (r > (64'd1 << IFRAC))
            r = 64'd1 << IFRAC;
        if (FB >= IFRAC)
            r = r << (FB - IFRAC);
        else
            r = (r + (64'd1 << (IFRAC - FB - 1))) >> (IFRAC - FB);
        if (r > (64'd1 << FB))
            r = 64'd1 << FB;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (r > lim)
            r = lim;
        return neg ? 32'(0 - r) : 32'(r);
    endfunction

    function automatic cube_t map_point(point_t p);
        logic [31:0] w[3];
        logic [31:0] res[3];
        logic [63:0] mag[3];
        logic [63:0] sq[3];
        logic        neg[3];
        logic [63:0] q;
        axis_t       face;
        int          ua;
        int          va;
        int          f;
        cube_t       c;
        w[0] = p.point_x;
        w[1] = p.point_y;
        w[2] = p.point_z;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = w[i][31];
            mag[i] = neg[i] ? 64'h1_0000_0000 - w[i] : 64'(w[i]);
            sq[i]  = twice_sq(mag[i]);
        end
        if (mag[0] >= mag[1] && mag[0] >= mag[2])
            face = AXIS_X;
        else if (mag[1] >= mag[2])
            face = AXIS_Y;
        else
            face = AXIS_Z;
        f  = int'(face);
        ua = (face == AXIS_X) ? 1 : 0;
        va = (face == AXIS_Z) ? 1 : 2;
        q  = outer_q(sq[ua], sq[va]);
        res[f]  = neg[f] ? ((FB >= 31) ? MNEG : MONE) : ((FB >= 31) ? 32'h7FFF_FFFF : ONE);
        res[ua] = (mag[ua] == 0) ? 32'd0 : tangent_coord(sq[ua], sq[va], q, neg[ua]);
        res[va] = (mag[va] == 0) ? 32'd0 : tangent_coord(sq[va], sq[ua], q, neg[va]);
        c.cube_x = res[0];
        c.cube_y = res[1];
        c.cube_z = res[2];
        return c;
    endfunction

    // ---------------- directed table ----------------
    typedef struct {
        point_t p;
        logic   known;   // expected value typed in below
        cube_t  c;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic dir_row_t mk(logic signed [31:0] x, logic signed [31:0] y,
                                    logic signed [31:0] z, int known,
                                    logic signed [31:0] cx, logic signed [31:0] cy,
                                    logic signed [31:0] cz);
        dir_row_t r;
        r.p     = '{x, y, z};
        r.known = (known != 0);
        r.c     = '{cx, cy, cz};
        return r;
    endfunction

    initial
    begin
        // axis poles and origin: face axis goes to +-1, zero tangents stay zero
        dir_rows.push_back(mk(0, 0, 0, 1, ONE, 0, 0));
        dir_rows.push_back(mk(ONE, 0, 0, 1, ONE, 0, 0));
        dir_rows.push_back(mk(MONE, 0, 0, 1, MONE, 0, 0));
        dir_rows.push_back(mk(0, ONE, 0, 1, 0, ONE, 0));
        dir_rows.push_back(mk(0, MONE, 0, 1, 0, MONE, 0));
        dir_rows.push_back(mk(0, 0, ONE, 1, 0, 0, ONE));
        dir_rows.push_back(mk(0, 0, MONE, 1, 0, 0, MONE));
        // most negative word clamps to -1.0
        dir_rows.push_back(mk(MNEG, 0, 0, 1, MONE, 0, 0));
        dir_rows.push_back(mk(0, 0, MNEG, 1, 0, 0, MONE));
        // ties: x wins over y and z, y over z
        dir_rows.push_back(mk(32'sd759250125, 32'sd759250125, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(0, -32'sd759250125, 32'sd759250125, 0, 0, 0, 0));
        dir_rows.push_back(mk(32'sd619925131, -32'sd619925131, 32'sd619925131, 0, 0, 0, 0));
        dir_rows.push_back(mk(-32'sd619925131, 32'sd619925131, -32'sd619925131, 0, 0, 0, 0));
        // off-sphere points and full-scale corners, some of which drive radicands negative
        dir_rows.push_back(mk(ONE, ONE, ONE, 0, 0, 0, 0));
        dir_rows.push_back(mk(MNEG, 32'sh7FFF_FFFF, MNEG, 0, 0, 0, 0));
        dir_rows.push_back(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, 0));
        dir_rows.push_back(mk(1, -1, 1, 0, 0, 0, 0));
        dir_rows.push_back(mk(-1, 0, 1, 0, 0, 0, 0));
        dir_rows.push_back(mk(32'sd100, 32'sd1073741823, -32'sd5, 0, 0, 0, 0));
        dir_rows.push_back(mk(32'sd10, -32'sd20, 32'sh7FFF_FFFF, 0, 0, 0, 0));
        dir_rows.push_back(mk(32'sh7FFF_FFFF, 32'sh8000_0001, 32'sh4000_0001, 0, 0, 0, 0));
    end

    // ---------------- random point generator ----------------
    function automatic logic signed [31:0] rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return $urandom;                       // any word, all bits toggle
            1:       return 0;
            2:       return $urandom_range(0, 1) ? ONE : MONE;
            3:       return $signed($urandom_range(0, 7)) - 3;
            default: return $signed($urandom_range(0, 2 * (1 << FB))) - ONE;
        endcase
    endfunction

    // 3 in 4: random unit direction via real math, then quantized; else rand_coord
    function automatic point_t rand_point();
        real    x;
        real    y;
        real    z;
        real    n;
        point_t p;
        if ($urandom_range(0, 3) == 0)
        begin
            p.point_x = rand_coord();
            p.point_y = rand_coord();
            p.point_z = rand_coord();
            return p;
        end
        x = real'($signed($urandom_range(0, 2000000))) - 1000000.0;
        y = real'($signed($urandom_range(0, 2000000))) - 1000000.0;
        z = real'($signed($urandom_range(0, 2000000))) - 1000000.0;
        n = $sqrt(x * x + y * y + z * z);
        if (n == 0.0)
            n = 1.0;
        p.point_x = $rtoi(x / n * real'(ONE));
        p.point_y = $rtoi(y / n * real'(ONE));
        p.point_z = $rtoi(z / n * real'(ONE));
        return p;
    endfunction

    // ---------------- result checker ----------------
    always @(posedge clk)
    begin
        cube_t want;
        if (rst_n && done)
        begin
            recv_cnt++;
            if (cube_pending.size() == 0)
            begin
                $error("result with no transfer pending: %h", cube);
                fail_cnt++;
            end
            else
            begin
                want = cube_pending.pop_front();
                if (cube.cube_x !== want.cube_x)
                begin
                    $error("cube_x expected %0d actual %0d", want.cube_x, cube.cube_x);
                    fail_cnt++;
                end
                if (cube.cube_y !== want.cube_y)
                begin
                    $error("cube_y expected %0d actual %0d", want.cube_y, cube.cube_y);
                    fail_cnt++;
                end
                if (cube.cube_z !== want.cube_z)
                begin
                    $error("cube_z expected %0d actual %0d", want.cube_z, cube.cube_z);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: cycles in which neither side moved a transfer.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= WATCHDOG)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    // Present one point and hold it until the transfer happens; a random gap
    // precedes it unless the quiet stretch is on.
    task automatic send_point(point_t p, cube_t exp_c, bit no_gaps);
        while (!no_gaps && $urandom_range(0, 99) < 13)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        point <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        cube_pending.push_back(exp_c);
        sent_cnt++;
    endtask

    initial
    begin
        int     dir_known;
        cube_t  c;
        point_t p;
        dir_known = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: typed-in expectations are also cross-checked
        // against the predictor so a table typo cannot hide
        foreach (dir_rows[i])
        begin
            c = map_point(dir_rows[i].p);
            if (dir_rows[i].known)
            begin
                dir_known++;
                if (c !== dir_rows[i].c)
                begin
                    $error("table row %0d expected %h predictor %h", i, dir_rows[i].c, c);
                    fail_cnt++;
                end
                c = dir_rows[i].c;
            end
            send_point(dir_rows[i].p, c, 1'b0);
        end

        // random part; items 400..699 run back to back with no gaps
        for (int n = 0; n < N_RANDOM; n++)
        begin
            p = rand_point();
            send_point(p, map_point(p), n >= 400 && n < 700);
        end
        start <= 1'b0;

        // drain, then keep clocking to catch stray strobes
        while (cube_pending.size() != 0)
            @(posedge clk);
        repeat (3 * LATENCY) @(posedge clk);

        $display("covered %0d points (%0d directed, %0d typed-in), %0d results seen",
                 sent_cnt, dir_rows.size(), dir_known, recv_cnt);
        if (fail_cnt == 0 && cube_pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/s2c_pkg.sv
rtl/s2c_isqrt.sv
rtl/s2c_front.sv
rtl/s2c_back.sv
rtl/sphere_to_cube_mapper_top.sv
rtl/s2c_checker.sv
sim/tb_sphere_to_cube_mapper_top.sv
